>>> rtl/yuv2rgb_pkg.sv
`timescale 1ns / 1ps

package yuv2rgb_pkg;

  // channel payload widths
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned COMP_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  // matrix arithmetic widths
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned OFFSET_W = 24;
  localparam int unsigned PROD_W   = 25;
  localparam int unsigned SUM_W    = 27;
  localparam int unsigned NUM_COLORS = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PACK_ORDER   = 3'd0,
    REG_RED_COEFFS   = 3'd1,
    REG_GREEN_COEFFS = 3'd2,
    REG_BLUE_COEFFS  = 3'd3,
    REG_RED_OFFSET   = 3'd4,
    REG_GREEN_OFFSET = 3'd5,
    REG_BLUE_OFFSET  = 3'd6
  } cfg_reg_t;

  // packed byte orders
  typedef enum logic [1:0] {
    PACK_YUY2 = 2'd0,
    PACK_YVYU = 2'd1,
    PACK_UYVY = 2'd2
  } pack_order_t;

endpackage

>>> rtl/yuv2rgb_if.sv
`timescale 1ns / 1ps

// packed macro-pixel stream
interface yuv2rgb_in_if
  import yuv2rgb_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] macro_word;

  modport source (output valid, output macro_word, input ready);
  modport sink   (input valid, input macro_word, output ready);
endinterface

// rgb pixel stream
interface yuv2rgb_out_if
  import yuv2rgb_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [COMP_W-1:0] red;
  logic [COMP_W-1:0] green;
  logic [COMP_W-1:0] blue;
  logic              last;

  modport source (output valid, output red, output green, output blue, output last,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input last,
                  output ready);
endinterface

// register write channel
interface yuv2rgb_cfg_if
  import yuv2rgb_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/packed_yuv422_to_rgb_converter.sv
`timescale 1ns / 1ps
// The even pixel of a macro-pixel passes the input, product and output registers, and the
// odd (last) pixel follows from the same held word. Throughput: one pixel per cycle while the
// output is not stalled; a new macro-pixel is taken as the odd pixel of the held one moves on.
// The single set of nine coefficient multipliers serves one pixel per cycle, shared by both
// pixels. Reset: config registers go to 0 (YUY2 order, zero matrix) and valid flags clear.

module packed_yuv422_to_rgb_converter
  import yuv2rgb_pkg::*;
#(
  parameter int unsigned COEFF_FRAC_BITS = 13
) (
  input  logic          clk,
  input  logic          rst,
  yuv2rgb_cfg_if.sink   cfg,
  yuv2rgb_in_if.sink    pix_in,
  yuv2rgb_out_if.source pix_out
);

  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (COEFF_FRAC_BITS - 1);

  // configuration registers
  logic [1:0]          pack_order;
  logic [3*COEF_W-1:0] coeffs  [NUM_COLORS];
  logic [OFFSET_W-1:0] offsets [NUM_COLORS];

  // input stage
  logic              s1_valid;
  logic              s1_phase;
  logic [COMP_W-1:0] s1_y0;
  logic [COMP_W-1:0] s1_y1;
  logic [COMP_W-1:0] s1_u;
  logic [COMP_W-1:0] s1_v;

  // product stage
  logic                     s2_valid;
  logic                     s2_last;
  logic signed [PROD_W-1:0] s2_prod [NUM_COLORS][3];

  // output stage
  logic              s3_valid;
  logic              s3_last;
  logic [COMP_W-1:0] s3_rgb [NUM_COLORS];

  logic s3_load;
  logic s2_load;
  logic emit;
  logic s1_free;
  logic in_xfer;

  logic [COMP_W-1:0] luma;
  logic [COMP_W-1:0] color_val [NUM_COLORS];

  // shift out the fraction and saturate to 0..255 (the caller adds HALF to round)
  function automatic logic [COMP_W-1:0] saturate(input logic signed [SUM_W-1:0] sum);
    logic signed [SUM_W-1:0] whole;
    whole = sum >>> COEFF_FRAC_BITS;
    if (sum[SUM_W-1]) begin
      saturate = '0;
    end else if (whole[SUM_W-1:COMP_W] != '0) begin
      saturate = '1;
    end else begin
      saturate = whole[COMP_W-1:0];
    end
  endfunction

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pack_order <= PACK_YUY2;
      for (int c = 0; c < NUM_COLORS; c++) begin
        coeffs[c]  <= '0;
        offsets[c] <= '0;
      end
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_PACK_ORDER:   pack_order <= cfg.data[1:0];
        REG_RED_COEFFS:   coeffs[0]  <= cfg.data;
        REG_GREEN_COEFFS: coeffs[1]  <= cfg.data;
        REG_BLUE_COEFFS:  coeffs[2]  <= cfg.data;
        REG_RED_OFFSET:   offsets[0] <= cfg.data[OFFSET_W-1:0];
        REG_GREEN_OFFSET: offsets[1] <= cfg.data[OFFSET_W-1:0];
        REG_BLUE_OFFSET:  offsets[2] <= cfg.data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // stage advance conditions
  assign s3_load      = !s3_valid || pix_out.ready;
  assign s2_load      = !s2_valid || s3_load;
  assign emit         = s1_valid && s2_load;
  assign s1_free      = emit && s1_phase;
  assign pix_in.ready = !s1_valid || s1_free;
  assign in_xfer      = pix_in.valid && pix_in.ready;

  // input register control: phase 0 emits the even pixel, phase 1 the odd one
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_phase <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
      s1_phase <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= 1'b0;
      s1_phase <= 1'b0;
    end else if (emit) begin
      s1_phase <= 1'b1;
    end
  end

  // unpack bytes by order
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      case (pack_order)
        PACK_UYVY: begin
          s1_u  <= pix_in.macro_word[7:0];
          s1_y0 <= pix_in.macro_word[15:8];
          s1_v  <= pix_in.macro_word[23:16];
          s1_y1 <= pix_in.macro_word[31:24];
        end
        PACK_YVYU: begin
          s1_y0 <= pix_in.macro_word[7:0];
          s1_v  <= pix_in.macro_word[15:8];
          s1_y1 <= pix_in.macro_word[23:16];
          s1_u  <= pix_in.macro_word[31:24];
        end
        default: begin
          s1_y0 <= pix_in.macro_word[7:0];
          s1_u  <= pix_in.macro_word[15:8];
          s1_y1 <= pix_in.macro_word[23:16];
          s1_v  <= pix_in.macro_word[31:24];
        end
      endcase
    end
  end

  assign luma = s1_phase ? s1_y1 : s1_y0;

  // coefficient products for the current pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s2_last <= s1_phase;
      for (int c = 0; c < NUM_COLORS; c++) begin
        s2_prod[c][0] <= $signed(coeffs[c][15:0])  * $signed({1'b0, luma});
        s2_prod[c][1] <= $signed(coeffs[c][31:16]) * $signed({1'b0, s1_u});
        s2_prod[c][2] <= $signed(coeffs[c][47:32]) * $signed({1'b0, s1_v});
      end
    end
  end

  // sum with offset and half, then saturate
  always_comb begin
    for (int c = 0; c < NUM_COLORS; c++) begin
      color_val[c] = saturate(SUM_W'(s2_prod[c][0]) + SUM_W'(s2_prod[c][1])
                              + SUM_W'(s2_prod[c][2])
                              + SUM_W'($signed(offsets[c])) + HALF);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_load) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load && s2_valid) begin
      s3_last <= s2_last;
      for (int c = 0; c < NUM_COLORS; c++) begin
        s3_rgb[c] <= color_val[c];
      end
    end
  end

  assign pix_out.valid = s3_valid;
  assign pix_out.red   = s3_rgb[0];
  assign pix_out.green = s3_rgb[1];
  assign pix_out.blue  = s3_rgb[2];
  assign pix_out.last  = s3_last;

  // odd phase only while an item is held
  a_phase_held: assert property (@(posedge clk) disable iff (rst)
    s1_phase |-> s1_valid)
    else $error("odd phase without a held item");

  // a new item always starts on the even pixel
  a_start_even: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> s1_valid && !s1_phase)
    else $error("accepted item does not start on the even pixel");

  // no new item while the even pixel is still pending
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_phase) |-> !pix_in.ready)
    else $error("input ready while the even pixel is pending");

  // odd pixel reaches the output marked last
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    (s3_load && s2_valid && s2_last) |=> pix_out.valid && pix_out.last)
    else $error("odd pixel lost its last mark");

endmodule

>>> sim/tb_packed_yuv422_to_rgb_converter.sv
`timescale 1ns / 1ps

module tb_packed_yuv422_to_rgb_converter;
  import yuv2rgb_pkg::*;

  localparam int unsigned COEFF_FRAC_BITS = 13;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_WORDS    = 65;
  localparam int EXTREME_WORDS  = 20;

  // color slots of the coefficient and offset mirrors
  localparam int C_RED   = 0;
  localparam int C_GREEN = 1;
  localparam int C_BLUE  = 2;

  // byte order code with no name of its own, decoded as yuy2
  localparam logic [1:0] ORDER_UNUSED = 2'd3;
  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // matrix styles for random settings
  localparam int STYLE_NEAR_BT601 = 0;
  localparam int STYLE_WILD       = 1;
  localparam int STYLE_MILD       = 2;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic              last;
  } rgb_pixel_t;

  logic clk;
  logic rst;

  yuv2rgb_cfg_if cfg_bus ();
  yuv2rgb_in_if  in_bus ();
  yuv2rgb_out_if out_bus ();

  packed_yuv422_to_rgb_converter #(
    .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .pix_in (in_bus),
    .pix_out(out_bus)
  );

  // register mirror used by the pixel predictor
  logic [1:0]            cur_order;
  logic [CFG_DATA_W-1:0] cur_coeffs  [NUM_COLORS];
  logic [OFFSET_W-1:0]   cur_offsets [NUM_COLORS];

  logic [WORD_W-1:0] pending_words [$];
  rgb_pixel_t        expected_pixels [$];
  int                words_queued;
  int                words_accepted;
  int                mismatches;

  int burst_left;
  int gap_left;
  int hold_req;
  int hold_ack;
  int hold_left;
  logic [31:0] stall_cycle;
  int idle_cycles;

  logic [WORD_W-1:0] corner_words [13] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h8080_8080, 32'h7F7F_7F7F,
    32'h01FE_01FE, 32'hFF00_FF00, 32'h00FF_00FF, 32'h8010_8010,
    32'h80EB_80EB, 32'h55AA_55AA, 32'h1234_5678, 32'hC040_8020,
    32'h00FF_80EB
  };

  always #2 clk = ~clk;

  // one color level: matrix row dot (y, u, v) plus offset, rounded and clamped
  function automatic logic [COMP_W-1:0] color_level(input logic [CFG_DATA_W-1:0] coeffs,
                                                    input logic [OFFSET_W-1:0] offset,
                                                    input logic [7:0] y,
                                                    input logic [7:0] u,
                                                    input logic [7:0] v);
    longint acc;
    longint whole;
    acc = longint'($signed(coeffs[15:0])) * longint'(y)
        + longint'($signed(coeffs[31:16])) * longint'(u)
        + longint'($signed(coeffs[47:32])) * longint'(v)
        + longint'($signed(offset))
        + (longint'(1) <<< (COEFF_FRAC_BITS - 1));
    if (acc < 0) return '0;
    whole = acc >>> COEFF_FRAC_BITS;
    if (whole > 255) return 8'hFF;
    return whole[7:0];
  endfunction

  // expected even and odd pixels for one macro-pixel word
  task automatic predict_pixels(input logic [WORD_W-1:0] word);
    logic [7:0] luma [2];
    logic [7:0] u;
    logic [7:0] v;
    rgb_pixel_t pixel;
    case (cur_order)
      PACK_UYVY: begin
        u = word[7:0]; luma[0] = word[15:8]; v = word[23:16]; luma[1] = word[31:24];
      end
      PACK_YVYU: begin
        luma[0] = word[7:0]; v = word[15:8]; luma[1] = word[23:16]; u = word[31:24];
      end
      default: begin
        luma[0] = word[7:0]; u = word[15:8]; luma[1] = word[23:16]; v = word[31:24];
      end
    endcase
    for (int k = 0; k < 2; k++) begin
      pixel.red   = color_level(cur_coeffs[C_RED], cur_offsets[C_RED], luma[k], u, v);
      pixel.green = color_level(cur_coeffs[C_GREEN], cur_offsets[C_GREEN], luma[k], u, v);
      pixel.blue  = color_level(cur_coeffs[C_BLUE], cur_offsets[C_BLUE], luma[k], u, v);
      pixel.last  = (k == 1);
      expected_pixels.push_back(pixel);
    end
  endtask

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pack_coeffs(input int y, input int u,
                                                       input int v);
    return {16'(v), 16'(u), 16'(y)};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_data();
    logic [CFG_DATA_W-1:0] d;
    d[31:0]  = $urandom;
    d[47:32] = 16'($urandom);
    return d;
  endfunction

  // random word, bytes sometimes pinned to the extremes
  function automatic logic [WORD_W-1:0] rand_word();
    logic [WORD_W-1:0] w;
    w = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      for (int b = 0; b < 4; b++) begin
        case ($urandom_range(0, 2))
          0: w[8*b +: 8] = 8'h00;
          1: w[8*b +: 8] = 8'hFF;
          default: ;
        endcase
      end
    end
    return w;
  endfunction

  // one register write transfer, mirror updated on acceptance
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_PACK_ORDER:   cur_order = value[1:0];
      REG_RED_COEFFS:   cur_coeffs[C_RED] = value;
      REG_GREEN_COEFFS: cur_coeffs[C_GREEN] = value;
      REG_BLUE_COEFFS:  cur_coeffs[C_BLUE] = value;
      REG_RED_OFFSET:   cur_offsets[C_RED] = value[OFFSET_W-1:0];
      REG_GREEN_OFFSET: cur_offsets[C_GREEN] = value[OFFSET_W-1:0];
      REG_BLUE_OFFSET:  cur_offsets[C_BLUE] = value[OFFSET_W-1:0];
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
  endtask

  // full register set, unused upper data bits filled with noise
  task automatic load_setting(input logic [1:0] order,
                              input logic [CFG_DATA_W-1:0] red_c,
                              input logic [CFG_DATA_W-1:0] green_c,
                              input logic [CFG_DATA_W-1:0] blue_c,
                              input logic [OFFSET_W-1:0] red_o,
                              input logic [OFFSET_W-1:0] green_o,
                              input logic [OFFSET_W-1:0] blue_o);
    logic [CFG_DATA_W-1:0] noise;
    noise = rand_data();
    write_register(REG_PACK_ORDER, {noise[CFG_DATA_W-1:2], order});
    write_register(REG_RED_COEFFS, red_c);
    write_register(REG_GREEN_COEFFS, green_c);
    write_register(REG_BLUE_COEFFS, blue_c);
    noise = rand_data();
    write_register(REG_RED_OFFSET, {noise[CFG_DATA_W-1:OFFSET_W], red_o});
    noise = rand_data();
    write_register(REG_GREEN_OFFSET, {noise[CFG_DATA_W-1:OFFSET_W], green_o});
    noise = rand_data();
    write_register(REG_BLUE_OFFSET, {noise[CFG_DATA_W-1:OFFSET_W], blue_o});
  endtask

  task automatic load_bt601(input logic [1:0] order);
    load_setting(order, pack_coeffs(8192, 0, 11485), pack_coeffs(8192, -2819, -5850),
                 pack_coeffs(8192, 14516, 0), 24'(-1470104), 24'(1109683),
                 24'(-1858077));
  endtask

  task automatic load_random_setting(input int style);
    logic [CFG_DATA_W-1:0] c [NUM_COLORS];
    logic [OFFSET_W-1:0]   o [NUM_COLORS];
    case (style)
      STYLE_NEAR_BT601: begin
        c[C_RED]   = pack_coeffs(rand_between(8128, 8256), rand_between(-64, 64),
                                 rand_between(11421, 11549));
        c[C_GREEN] = pack_coeffs(rand_between(8128, 8256), rand_between(-2883, -2755),
                                 rand_between(-5914, -5786));
        c[C_BLUE]  = pack_coeffs(rand_between(8128, 8256), rand_between(14452, 14580),
                                 rand_between(-64, 64));
        o[C_RED]   = 24'(rand_between(-1470104 - 32768, -1470104 + 32768));
        o[C_GREEN] = 24'(rand_between(1109683 - 32768, 1109683 + 32768));
        o[C_BLUE]  = 24'(rand_between(-1858077 - 32768, -1858077 + 32768));
      end
      STYLE_WILD: begin
        for (int i = 0; i < NUM_COLORS; i++) begin
          c[i] = rand_data();
          o[i] = 24'($urandom);
        end
      end
      default: begin
        for (int i = 0; i < NUM_COLORS; i++) begin
          c[i] = pack_coeffs(rand_between(-4096, 4096), rand_between(-4096, 4096),
                             rand_between(-4096, 4096));
          o[i] = 24'(rand_between(-(1 << 21), 1 << 21));
        end
      end
    endcase
    load_setting(2'($urandom_range(0, 3)), c[C_RED], c[C_GREEN], c[C_BLUE],
                 o[C_RED], o[C_GREEN], o[C_BLUE]);
  endtask

  task automatic queue_word(input logic [WORD_W-1:0] word);
    pending_words.push_back(word);
    words_queued++;
  endtask

  task automatic queue_random_words(input int count);
    for (int i = 0; i < count; i++) queue_word(rand_word());
  endtask

  // block idle: every word taken and every pixel seen
  task automatic wait_idle();
    while (words_accepted != words_queued || expected_pixels.size() != 0) @(posedge clk);
  endtask

  // macro-pixel sender, bursts separated by random gaps
  always @(posedge clk) begin : drive_words
    logic              next_valid;
    logic [WORD_W-1:0] next_word;
    if (rst) begin
      in_bus.valid      <= 1'b0;
      in_bus.macro_word <= '0;
    end else begin
      next_valid = in_bus.valid;
      next_word  = in_bus.macro_word;
      if (in_bus.valid && in_bus.ready) begin
        predict_pixels(in_bus.macro_word);
        words_accepted++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() > 0) begin
          next_word  = pending_words.pop_front();
          next_valid = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      in_bus.valid      <= next_valid;
      in_bus.macro_word <= next_word;
    end
  end

  // pixel receiver: four stall patterns in turn, chosen by stall_cycle[7:6], long hold on request
  always @(posedge clk) begin : drive_ready
    logic next_ready;
    if (rst) begin
      out_bus.ready <= 1'b0;
    end else begin
      stall_cycle++;
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else begin
        case (stall_cycle[7:6])
          2'd0: next_ready = 1'b1;
          2'd1: next_ready = 1'($urandom_range(0, 1));
          2'd2: next_ready = (stall_cycle[1:0] == 2'd0);
          default: next_ready = ($urandom_range(0, 3) != 0);
        endcase
      end
      out_bus.ready <= next_ready;
    end
  end

  // pixel checker against the oldest expectation
  always @(posedge clk) begin : check_pixels
    rgb_pixel_t want;
    if (!rst && out_bus.valid && out_bus.ready) begin
      if (expected_pixels.size() == 0) begin
        note_mismatch($sformatf("unexpected pixel r=%0d g=%0d b=%0d last=%0b",
                                out_bus.red, out_bus.green, out_bus.blue, out_bus.last));
      end else begin
        want = expected_pixels.pop_front();
        if (out_bus.red !== want.red || out_bus.green !== want.green ||
            out_bus.blue !== want.blue || out_bus.last !== want.last) begin
          note_mismatch($sformatf(
            "pixel mismatch: exp r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
            want.red, want.green, want.blue, want.last,
            out_bus.red, out_bus.green, out_bus.blue, out_bus.last));
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin : watchdog
    if (rst || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk               = 1'b0;
    rst               = 1'b1;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = '0;
    cfg_bus.data      = '0;
    in_bus.valid      = 1'b0;
    in_bus.macro_word = '0;
    out_bus.ready     = 1'b0;
    cur_order         = PACK_YUY2;
    for (int i = 0; i < NUM_COLORS; i++) begin
      cur_coeffs[i]  = '0;
      cur_offsets[i] = '0;
    end
    words_queued   = 0;
    words_accepted = 0;
    mismatches     = 0;
    burst_left     = 0;
    gap_left       = 0;
    hold_req       = 0;
    hold_ack       = 0;
    hold_left      = 0;
    stall_cycle    = '0;
    idle_cycles    = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // zero matrix after reset
    queue_word(32'h0000_0000);
    queue_word(32'hFFFF_FFFF);
    wait_idle();

    // bt.601 full range, all corner words in yuy2 and three of them in each other byte order
    load_bt601(PACK_YUY2);
    foreach (corner_words[i]) queue_word(corner_words[i]);
    wait_idle();
    load_bt601(PACK_YVYU);
    for (int i = 10; i < 13; i++) queue_word(corner_words[i]);
    wait_idle();
    load_bt601(PACK_UYVY);
    for (int i = 10; i < 13; i++) queue_word(corner_words[i]);
    wait_idle();
    load_bt601(ORDER_UNUSED);
    for (int i = 10; i < 13; i++) queue_word(corner_words[i]);
    wait_idle();

    // saturation at the top: largest coefficients and offsets
    load_setting(PACK_YUY2, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
                 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF);
    queue_random_words(EXTREME_WORDS);
    wait_idle();

    // clamp at zero: most negative coefficients and offsets
    load_setting(PACK_UYVY, 48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
                 24'h80_0000, 24'h80_0000, 24'h80_0000);
    queue_random_words(EXTREME_WORDS);
    wait_idle();

    // write to the index with no register, must change nothing
    write_register(REG_UNUSED, rand_data());
    queue_random_words(EXTREME_WORDS);
    wait_idle();

    // random settings, one phase under a long output hold
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_random_setting(p % 3);
      if (p == 3) hold_req <= hold_req + 1;
      queue_random_words(PHASE_WORDS);
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
